// File: sv/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and codes of the periodic task timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // Command codes of an input beat.
  typedef enum logic [2:0] {
    OP_TICK = 3'd0,
    OP_REG  = 3'd1,
    OP_DEL  = 3'd2,
    OP_MOD  = 3'd3,
    OP_EXEC = 3'd4
  } op_e;

  // Result kinds of an output beat.
  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_RD,
    ST_EV,
    ST_EMIT
  } state_e;

  localparam int CNT_W     = 16;
  localparam int SLOT_W    = 4;
  localparam int MAX_FIRE  = 16;
  localparam int FIRE_W    = $clog2(MAX_FIRE + 1);

  typedef logic [SLOT_W-1:0] slot_num_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic      valid;
    kind_e     kind;
    slot_num_t slot;
    logic      last;
  } emit_t;

  // Slot memory controls.
  typedef struct packed {
    logic rd_en;
    logic cnt_we;
    logic per_we;
  } mem_ctl_t;

endpackage

// File: sv/ptt_slot_mem.sv
// ----------------------------------------------------------------------------
// ptt_slot_mem
// Countdown and period storage, one write and one registered read port each.
// ----------------------------------------------------------------------------
module ptt_slot_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk_i,
  input  ptt_pkg::mem_ctl_t   ctl_i,
  input  logic [AW-1:0]       rd_addr_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  ptt_pkg::cnt_t       cnt_wdata_i,
  input  ptt_pkg::cnt_t       per_wdata_i,
  output ptt_pkg::cnt_t       cnt_rdata_o,
  output ptt_pkg::cnt_t       per_rdata_o
);

  ptt_pkg::cnt_t cnt_mem [DEPTH];
  ptt_pkg::cnt_t per_mem [DEPTH];
  ptt_pkg::cnt_t cnt_rdata_q;
  ptt_pkg::cnt_t per_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.cnt_we) begin
      cnt_mem[wr_addr_i] <= cnt_wdata_i;
    end
    if (ctl_i.per_we) begin
      per_mem[wr_addr_i] <= per_wdata_i;
    end
    if (ctl_i.rd_en) begin
      cnt_rdata_q <= cnt_mem[rd_addr_i];
      per_rdata_q <= per_mem[rd_addr_i];
    end
  end

  assign cnt_rdata_o = cnt_rdata_q;
  assign per_rdata_o = per_rdata_q;

endmodule

// File: sv/ptt_seq.sv
// ----------------------------------------------------------------------------
// ptt_seq
// Command sequencer: walks the slots one at a time for tick, register and
// execute, and holds the used and pending marks.
// ----------------------------------------------------------------------------
module ptt_seq #(
  parameter int NUM_SLOTS = 16,
  parameter int IDX_W     = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           opcode_i,
  input  logic [7:0]           slot_index_i,
  input  ptt_pkg::cnt_t        start_delay_i,
  input  ptt_pkg::cnt_t        reload_value_i,
  output ptt_pkg::emit_t       emit_o,
  input  logic                 out_free_i,
  output ptt_pkg::mem_ctl_t    mem_ctl_o,
  output logic [IDX_W-1:0]     mem_rd_addr_o,
  output logic [IDX_W-1:0]     mem_wr_addr_o,
  output ptt_pkg::cnt_t        cnt_wdata_o,
  output ptt_pkg::cnt_t        per_wdata_o,
  input  ptt_pkg::cnt_t        cnt_rdata_i,
  input  ptt_pkg::cnt_t        per_rdata_i
);

  localparam logic [IDX_W-1:0] LAST_PTR = IDX_W'(NUM_SLOTS - 1);
  localparam logic [ptt_pkg::FIRE_W-1:0] FIRE_LAST = ptt_pkg::FIRE_W'(ptt_pkg::MAX_FIRE - 1);

  ptt_pkg::state_e state_q, state_d;
  ptt_pkg::op_e    op_q, op_d;
  ptt_pkg::cnt_t   delay_q, delay_d;
  ptt_pkg::cnt_t   reload_q, reload_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [ptt_pkg::FIRE_W-1:0] fired_q, fired_d;
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [NUM_SLOTS-1:0] pend_q, pend_d;
  ptt_pkg::kind_e     res_kind_q, res_kind_d;
  ptt_pkg::slot_num_t res_slot_q, res_slot_d;

  logic             in_range;
  logic             ptr_end;
  logic             more_pending;
  logic [NUM_SLOTS-1:0] above;
  ptt_pkg::cnt_t    cnt_dec;
  logic             fire_last;

  assign in_range = {1'b0, slot_index_i} < 9'(NUM_SLOTS);
  assign ptr_end  = (ptr_q == LAST_PTR);
  assign cnt_dec  = (cnt_rdata_i != '0) ? cnt_rdata_i - 16'd1 : cnt_rdata_i;

  // slots above the walk pointer that still wait to fire
  always_comb begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      above[j] = (j > int'(ptr_q));
    end
  end
  assign more_pending = |(used_q & pend_q & above);
  assign fire_last    = !more_pending || (fired_q == FIRE_LAST);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    delay_d    = delay_q;
    reload_d   = reload_q;
    ptr_d      = ptr_q;
    fired_d    = fired_q;
    used_d     = used_q;
    pend_d     = pend_q;
    res_kind_d = res_kind_q;
    res_slot_d = res_slot_q;

    mem_ctl_o     = '0;
    mem_rd_addr_o = ptr_q;
    mem_wr_addr_o = ptr_q;
    cnt_wdata_o   = '0;
    per_wdata_o   = reload_q;
    emit_o        = '0;

    in_ready_o = (state_q == ptt_pkg::ST_IDLE);

    unique case (state_q)
      ptt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d       = ptt_pkg::op_e'(opcode_i);
          delay_d    = start_delay_i;
          reload_d   = reload_value_i;
          ptr_d      = '0;
          fired_d    = '0;
          res_kind_d = ptt_pkg::KIND_ACK;
          res_slot_d = '0;
          case (ptt_pkg::op_e'(opcode_i)) inside
            ptt_pkg::OP_TICK, ptt_pkg::OP_EXEC: begin
              state_d = ptt_pkg::ST_RD;
            end
            ptt_pkg::OP_REG: begin
              state_d = ptt_pkg::ST_FIND;
            end
            ptt_pkg::OP_DEL: begin
              if (in_range) begin
                used_d[slot_index_i[IDX_W-1:0]] = 1'b0;
                pend_d[slot_index_i[IDX_W-1:0]] = 1'b0;
              end
              state_d = ptt_pkg::ST_EMIT;
            end
            ptt_pkg::OP_MOD: begin
              if (in_range) begin
                mem_ctl_o.per_we = 1'b1;
                mem_wr_addr_o    = slot_index_i[IDX_W-1:0];
                per_wdata_o      = reload_value_i;
              end
              state_d = ptt_pkg::ST_EMIT;
            end
            default: begin
              state_d = ptt_pkg::ST_EMIT;
            end
          endcase
        end
      end

      ptt_pkg::ST_FIND: begin
        if (!used_q[ptr_q]) begin
          mem_ctl_o.cnt_we = 1'b1;
          mem_ctl_o.per_we = 1'b1;
          cnt_wdata_o      = delay_q;
          per_wdata_o      = reload_q;
          used_d[ptr_q]    = 1'b1;
          pend_d[ptr_q]    = 1'b0;
          res_slot_d       = ptt_pkg::slot_num_t'(ptr_q);
          state_d          = ptt_pkg::ST_EMIT;
        end else if (ptr_end) begin
          res_kind_d = ptt_pkg::KIND_FULL;
          state_d    = ptt_pkg::ST_EMIT;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      ptt_pkg::ST_RD: begin
        mem_ctl_o.rd_en = 1'b1;
        state_d         = ptt_pkg::ST_EV;
      end

      ptt_pkg::ST_EV: begin
        if (op_q == ptt_pkg::OP_TICK) begin
          if (used_q[ptr_q]) begin
            mem_ctl_o.cnt_we = 1'b1;
            if (cnt_dec == '0) begin
              cnt_wdata_o   = per_rdata_i;
              pend_d[ptr_q] = 1'b1;
            end else begin
              cnt_wdata_o = cnt_dec;
            end
          end
          if (ptr_end) begin
            state_d = ptt_pkg::ST_EMIT;
          end else begin
            ptr_d   = ptr_q + 1'b1;
            state_d = ptt_pkg::ST_RD;
          end
        end else if (used_q[ptr_q] && pend_q[ptr_q]) begin
          emit_o.valid = 1'b1;
          emit_o.kind  = ptt_pkg::KIND_FIRED;
          emit_o.slot  = ptt_pkg::slot_num_t'(ptr_q);
          emit_o.last  = fire_last;
          if (out_free_i) begin
            pend_d[ptr_q] = 1'b0;
            if (per_rdata_i == '0) begin
              used_d[ptr_q] = 1'b0;
            end
            fired_d = fired_q + 1'b1;
            if (fire_last) begin
              state_d = ptt_pkg::ST_IDLE;
            end else begin
              ptr_d   = ptr_q + 1'b1;
              state_d = ptt_pkg::ST_RD;
            end
          end
        end else if (ptr_end) begin
          res_kind_d = ptt_pkg::KIND_NONE;
          state_d    = (fired_q == '0) ? ptt_pkg::ST_EMIT : ptt_pkg::ST_IDLE;
        end else begin
          ptr_d   = ptr_q + 1'b1;
          state_d = ptt_pkg::ST_RD;
        end
      end

      ptt_pkg::ST_EMIT: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = res_kind_q;
        emit_o.slot  = res_slot_q;
        emit_o.last  = 1'b1;
        if (out_free_i) begin
          state_d = ptt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ptt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptt_pkg::ST_IDLE;
      used_q  <= '0;
      pend_q  <= '0;
      ptr_q   <= '0;
      fired_q <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      pend_q  <= pend_d;
      ptr_q   <= ptr_d;
      fired_q <= fired_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    delay_q    <= delay_d;
    reload_q   <= reload_d;
    res_kind_q <= res_kind_d;
    res_slot_q <= res_slot_d;
  end

  // a fired beat always names a live, pending slot
  a_fired_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && emit_o.kind == ptt_pkg::KIND_FIRED) |->
      (used_q[ptr_q] && pend_q[ptr_q]))
    else $error("fired beat for a slot that is not pending");

  // an execute walk never emits beyond the per-command limit
  a_fire_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptt_pkg::ST_EV && op_q == ptt_pkg::OP_EXEC) |->
      (fired_q < ptt_pkg::FIRE_W'(ptt_pkg::MAX_FIRE)))
    else $error("execute fired count over limit");

  // a single result handed off returns the sequencer to idle
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptt_pkg::ST_EMIT && out_free_i) |=> (state_q == ptt_pkg::ST_IDLE))
    else $error("sequencer stuck after final beat");

endmodule

// File: sv/periodic_task_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_task_timer_table
// Timer slot table of a cooperative scheduler: tick, register, delete,
// modify and execute commands, with fired slots reported as result beats.
// ----------------------------------------------------------------------------
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid_i/in_ready_o, opcode_i, slot_index_i, | in
//           | start_delay_i, reload_value_i                  |
//   out     | out_valid_o/out_ready_i, kind_o,               | out
//           | slot_number_o, last_o                          |
//
// Walks: tick walks every slot through the single read port of the slot
//   memory, a read and an evaluate state a slot; execute walks the same way
//   but stops at its last fired beat. Register scans the used marks one slot a cycle.
//   Delete, modify and unknown codes go straight to the result beat.
// Reset: used and pending marks clear at once; countdown and period memories
//   are not cleared and hold garbage until a slot is registered.
// Stalls: a held output beat stops the walk in place; the next command beat
//   is taken once the last result beat of the current one is registered.
// ----------------------------------------------------------------------------
module periodic_task_timer_table #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  slot_index_i,
  input  logic [15:0] start_delay_i,
  input  logic [15:0] reload_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  slot_number_o,
  output logic        last_o
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  ptt_pkg::emit_t    emit;
  ptt_pkg::mem_ctl_t mem_ctl;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [IDX_W-1:0]  mem_wr_addr;
  ptt_pkg::cnt_t     cnt_wdata;
  ptt_pkg::cnt_t     per_wdata;
  ptt_pkg::cnt_t     cnt_rdata;
  ptt_pkg::cnt_t     per_rdata;
  logic              out_free;

  // output register
  logic               out_valid_q;
  ptt_pkg::kind_e     kind_q;
  ptt_pkg::slot_num_t slot_q;
  logic               last_q;

  // the output stage can take a beat when empty or draining this cycle
  assign out_free = !out_valid_q || out_ready_i;

  ptt_seq #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .slot_index_i   (slot_index_i),
    .start_delay_i  (start_delay_i),
    .reload_value_i (reload_value_i),
    .emit_o         (emit),
    .out_free_i     (out_free),
    .mem_ctl_o      (mem_ctl),
    .mem_rd_addr_o  (mem_rd_addr),
    .mem_wr_addr_o  (mem_wr_addr),
    .cnt_wdata_o    (cnt_wdata),
    .per_wdata_o    (per_wdata),
    .cnt_rdata_i    (cnt_rdata),
    .per_rdata_i    (per_rdata)
  );

  ptt_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i       (clk_i),
    .ctl_i       (mem_ctl),
    .rd_addr_i   (mem_rd_addr),
    .wr_addr_i   (mem_wr_addr),
    .cnt_wdata_i (cnt_wdata),
    .per_wdata_i (per_wdata),
    .cnt_rdata_o (cnt_rdata),
    .per_rdata_o (per_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit.valid;
    end
  end

  // payload loads only with a new beat
  always_ff @(posedge clk_i) begin
    if (out_free && emit.valid) begin
      kind_q <= emit.kind;
      slot_q <= emit.slot;
      last_q <= emit.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign slot_number_o = slot_q;
  assign last_o        = last_q;

endmodule
